[hw/rtl/vector_error_metric_accumulator_core_macros.svh]
// Assertion macros for the vector error metric accumulator.
`ifndef VECTOR_ERROR_METRIC_ACCUMULATOR_CORE_MACROS_SVH
`define VECTOR_ERROR_METRIC_ACCUMULATOR_CORE_MACROS_SVH

// Check a property on every clock edge outside reset.
`define VEMA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define VEMA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/vema_pkg.sv]
// Shared types and constants of the vector error metric accumulator.
package vema_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int COMP_W         = 24;
    localparam int ITEM_W         = 6 * COMP_W + 1;
    localparam int SQ_W           = 50;
    localparam int ROOT_W         = 25;
    localparam int QDEPTH         = 2;
    localparam int FLOOR_W        = 16;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_SQ_E,
        S_SQ_M,
        S_ACC,
        S_DIVE_GO,
        S_DIVE_WAIT,
        S_DIVM_GO,
        S_DIVM_WAIT,
        S_DIVR_GO,
        S_DIVR_WAIT,
        S_OUT
    } back_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

[hw/rtl/vema_queue.sv]
// Item queue between the accepting front and the compute back end.
module vema_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  logic [vema_pkg::ITEM_W-1:0]   push_data,
    output logic                          full,
    input  logic                          pop,
    output logic                          empty,
    output logic [vema_pkg::ITEM_W-1:0]   head
);
    localparam int PW = $clog2(vema_pkg::QDEPTH);

    logic [vema_pkg::ITEM_W-1:0] mem [vema_pkg::QDEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW:0]   fill_reg, fill_next;

    assign full  = (fill_reg == (PW+1)'(vema_pkg::QDEPTH));
    assign empty = (fill_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !full)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(vema_pkg::QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop && !empty)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(vema_pkg::QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if ((push && !full) && !(pop && !empty))
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (!(push && !full) && (pop && !empty))
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[hw/rtl/vema_div.sv]
// Restoring divider, one quotient bit per cycle.
module vema_div #(
    parameter int NW = 42,
    parameter int DW = 24
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [NW-1:0]         numer,
    input  logic [DW-1:0]         denom,
    output vema_pkg::div_stat_t   stat,
    output logic [NW-1:0]         quot
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg, q_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] d_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [DW:0]   sh;
    logic          ge;

    assign sh   = {rem_reg, q_reg[NW-1]};
    assign ge   = (sh >= {1'b0, d_reg});
    assign quot = q_reg;
    assign stat = '{busy: busy_reg, done: done_reg};

    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next    = numer;
            rem_next  = '0;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? DW'(sh - {1'b0, d_reg}) : sh[DW-1:0];
            q_next   = {q_reg[NW-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        if (start)
        begin
            d_reg <= denom;
        end
    end

endmodule

[hw/rtl/vema_back.sv]
// Back end: lengths, accumulation, run-end divisions and result register.
`include "vector_error_metric_accumulator_core_macros.svh"
module vema_back #(
    parameter int COUNT_BITS = vema_pkg::COUNT_BITS_DEF,
    parameter int FRAC_BITS  = vema_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    input  logic [vema_pkg::ITEM_W-1:0]   q_head,
    output logic                          q_pop,
    input  logic [vema_pkg::FLOOR_W-1:0]  floor_val,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [16:0]                   pair_count,
    output logic [24:0]                   mean_error,
    output logic [24:0]                   peak_error,
    output logic [23:0]                   mean_magnitude,
    output logic [31:0]                   ratio_error,
    output logic                          overflow
);
    localparam int CNT_W  = COUNT_BITS + 1;
    localparam int ESUM_W = 25 + CNT_W;
    localparam int MSUM_W = 24 + CNT_W;
    localparam int RNUM_W = 25 + FRAC_BITS;
    localparam int NW     = (ESUM_W > RNUM_W) ? ESUM_W : RNUM_W;
    localparam int DW     = (CNT_W > 24) ? CNT_W : 24;
    localparam int CW     = vema_pkg::COMP_W;
    localparam int SQ_W   = vema_pkg::SQ_W;
    localparam int RT_W   = vema_pkg::ROOT_W;
    localparam logic [CNT_W-1:0] BOUND = {1'b1, {COUNT_BITS{1'b0}}};

    vema_pkg::back_state_t state_reg, state_next;

    logic [vema_pkg::ITEM_W-1:0] item_reg;
    logic [2:0]        mul_cnt_reg;
    logic [49:0]       prod_reg;
    logic [SQ_W-1:0]   esq_reg, msq_reg, rad_reg;
    logic [RT_W-1:0]   root_reg;
    logic [27:0]       rem_reg;
    logic [4:0]        step_reg;
    logic [RT_W-1:0]   err_len_reg;
    logic [23:0]       mag_len_reg;
    logic [ESUM_W-1:0] esum_reg;
    logic [MSUM_W-1:0] msum_reg;
    logic [24:0]       peak_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              ovf_reg;
    logic [24:0]       mean_e_reg;
    logic [23:0]       mean_m_reg;
    logic [31:0]       ratio_reg;
    logic              out_valid_reg;
    logic [16:0]       o_cnt_reg;
    logic [24:0]       o_mean_e_reg, o_peak_reg;
    logic [23:0]       o_mean_m_reg;
    logic [31:0]       o_ratio_reg;
    logic              o_ovf_reg;

    logic              div_start;
    logic [NW-1:0]     div_numer;
    logic [DW-1:0]     div_denom;
    vema_pkg::div_stat_t div_stat;
    logic [NW-1:0]     div_quot;

    logic signed [CW:0] op_s;
    logic [24:0]        op_abs;
    logic [27:0]        rem_sh, trial, rem_n;
    logic               sq_ge;
    logic [RT_W-1:0]    root_n;
    logic               at_bound;
    logic               is_last;

    logic [ESUM_W+NW-1:0] esum_ext;
    logic [MSUM_W+NW-1:0] msum_ext;
    logic [RNUM_W+NW-1:0] rnum_ext;
    logic [CNT_W+DW-1:0]  cnt_ext;
    logic [CNT_W+16:0]    cnt_out_ext;

    assign at_bound = (cnt_reg == BOUND);
    assign is_last  = item_reg[vema_pkg::ITEM_W-1];

    always_comb
    begin
        if (mul_cnt_reg < 3'd3)
        begin
            op_s = $signed({item_reg[mul_cnt_reg*CW + CW-1], item_reg[mul_cnt_reg*CW +: CW]})
                 - $signed({item_reg[(mul_cnt_reg+3)*CW + CW-1],
                            item_reg[(mul_cnt_reg+3)*CW +: CW]});
        end
        else
        begin
            op_s = $signed({item_reg[mul_cnt_reg*CW + CW-1], item_reg[mul_cnt_reg*CW +: CW]});
        end
        op_abs = op_s[CW] ? 25'(-op_s) : 25'(op_s);
    end

    assign rem_sh = {rem_reg[25:0], rad_reg[SQ_W-1 -: 2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign sq_ge  = (rem_sh >= trial);
    assign rem_n  = sq_ge ? (rem_sh - trial) : rem_sh;
    assign root_n = {root_reg[RT_W-2:0], sq_ge};

    assign esum_ext    = {{NW{1'b0}}, esum_reg};
    assign msum_ext    = {{NW{1'b0}}, msum_reg};
    assign rnum_ext    = {{NW{1'b0}}, mean_e_reg, {FRAC_BITS{1'b0}}};
    assign cnt_ext     = {{DW{1'b0}}, cnt_reg};
    assign cnt_out_ext = {17'b0, cnt_reg};

    always_comb
    begin
        unique case (state_reg)
            vema_pkg::S_DIVM_GO: div_numer = msum_ext[NW-1:0];
            vema_pkg::S_DIVR_GO: div_numer = rnum_ext[NW-1:0];
            default:             div_numer = esum_ext[NW-1:0];
        endcase
        div_denom = (state_reg == vema_pkg::S_DIVR_GO) ? DW'(mean_m_reg) : cnt_ext[DW-1:0];
    end

    vema_div #(
        .NW (NW),
        .DW (DW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (div_numer),
        .denom (div_denom),
        .stat  (div_stat),
        .quot  (div_quot)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            vema_pkg::S_IDLE:
            begin
                if (!q_empty)
                begin
                    if (cnt_reg != BOUND)
                    begin
                        state_next = vema_pkg::S_MUL;
                    end
                    else if (q_head[vema_pkg::ITEM_W-1])
                    begin
                        state_next = vema_pkg::S_DIVE_GO;
                    end
                end
            end
            vema_pkg::S_MUL:
            begin
                if (mul_cnt_reg == 3'd6)
                begin
                    state_next = vema_pkg::S_SQ_E;
                end
            end
            vema_pkg::S_SQ_E:
            begin
                if (step_reg == 5'(RT_W - 1))
                begin
                    state_next = vema_pkg::S_SQ_M;
                end
            end
            vema_pkg::S_SQ_M:
            begin
                if (step_reg == 5'(RT_W - 1))
                begin
                    state_next = vema_pkg::S_ACC;
                end
            end
            vema_pkg::S_ACC:
            begin
                state_next = is_last ? vema_pkg::S_DIVE_GO : vema_pkg::S_IDLE;
            end
            vema_pkg::S_DIVE_GO:   state_next = vema_pkg::S_DIVE_WAIT;
            vema_pkg::S_DIVE_WAIT:
            begin
                if (div_stat.done)
                begin
                    state_next = vema_pkg::S_DIVM_GO;
                end
            end
            vema_pkg::S_DIVM_GO:   state_next = vema_pkg::S_DIVM_WAIT;
            vema_pkg::S_DIVM_WAIT:
            begin
                if (div_stat.done)
                begin
                    state_next = (24'(div_quot) > 24'(floor_val)) ?
                                 vema_pkg::S_DIVR_GO : vema_pkg::S_OUT;
                end
            end
            vema_pkg::S_DIVR_GO:   state_next = vema_pkg::S_DIVR_WAIT;
            vema_pkg::S_DIVR_WAIT:
            begin
                if (div_stat.done)
                begin
                    state_next = vema_pkg::S_OUT;
                end
            end
            vema_pkg::S_OUT:
            begin
                if (!out_valid_reg)
                begin
                    state_next = vema_pkg::S_IDLE;
                end
            end
            default: state_next = vema_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop     = (state_reg == vema_pkg::S_IDLE) && !q_empty;
        div_start = (state_reg == vema_pkg::S_DIVE_GO) || (state_reg == vema_pkg::S_DIVM_GO)
                 || (state_reg == vema_pkg::S_DIVR_GO);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vema_pkg::S_IDLE;
            esum_reg      <= '0;
            msum_reg      <= '0;
            peak_reg      <= '0;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (q_pop && at_bound)
            begin
                ovf_reg <= 1'b1;
            end
            if (state_reg == vema_pkg::S_ACC)
            begin
                esum_reg <= esum_reg + ESUM_W'(err_len_reg);
                msum_reg <= msum_reg + MSUM_W'(mag_len_reg);
                if (err_len_reg > peak_reg)
                begin
                    peak_reg <= err_len_reg;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
            if ((state_reg == vema_pkg::S_OUT) && !out_valid_reg)
            begin
                out_valid_reg <= 1'b1;
                esum_reg      <= '0;
                msum_reg      <= '0;
                peak_reg      <= '0;
                cnt_reg       <= '0;
                ovf_reg       <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg) inside
            vema_pkg::S_IDLE:
            begin
                item_reg    <= q_head;
                mul_cnt_reg <= '0;
                esq_reg     <= '0;
                msq_reg     <= '0;
                ratio_reg   <= '0;
            end
            vema_pkg::S_MUL:
            begin
                prod_reg    <= op_abs * op_abs;
                mul_cnt_reg <= mul_cnt_reg + 1'b1;
                if (mul_cnt_reg >= 3'd1 && mul_cnt_reg <= 3'd3)
                begin
                    esq_reg <= esq_reg + prod_reg;
                end
                else if (mul_cnt_reg >= 3'd4)
                begin
                    msq_reg <= msq_reg + prod_reg;
                end
                if (mul_cnt_reg == 3'd6)
                begin
                    rad_reg  <= esq_reg;
                    rem_reg  <= '0;
                    root_reg <= '0;
                    step_reg <= '0;
                end
            end
            vema_pkg::S_SQ_E, vema_pkg::S_SQ_M:
            begin
                rad_reg  <= rad_reg << 2;
                rem_reg  <= rem_n;
                root_reg <= root_n;
                step_reg <= step_reg + 1'b1;
                if (step_reg == 5'(RT_W - 1))
                begin
                    rad_reg  <= msq_reg;
                    rem_reg  <= '0;
                    root_reg <= '0;
                    step_reg <= '0;
                    if (state_reg == vema_pkg::S_SQ_E)
                    begin
                        err_len_reg <= root_n;
                    end
                    else
                    begin
                        mag_len_reg <= root_n[23:0];
                    end
                end
            end
            vema_pkg::S_DIVE_WAIT:
            begin
                if (div_stat.done)
                begin
                    mean_e_reg <= div_quot[24:0];
                end
            end
            vema_pkg::S_DIVM_WAIT:
            begin
                if (div_stat.done)
                begin
                    mean_m_reg <= div_quot[23:0];
                end
            end
            vema_pkg::S_DIVR_WAIT:
            begin
                if (div_stat.done)
                begin
                    ratio_reg <= (div_quot[NW-1:32] != '0) ? '1 : div_quot[31:0];
                end
            end
            vema_pkg::S_OUT:
            begin
                if (!out_valid_reg)
                begin
                    o_cnt_reg    <= cnt_out_ext[16:0];
                    o_mean_e_reg <= mean_e_reg;
                    o_peak_reg   <= peak_reg;
                    o_mean_m_reg <= mean_m_reg;
                    o_ratio_reg  <= ratio_reg;
                    o_ovf_reg    <= ovf_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign pair_count     = o_cnt_reg;
    assign mean_error     = o_mean_e_reg;
    assign peak_error     = o_peak_reg;
    assign mean_magnitude = o_mean_m_reg;
    assign ratio_error    = o_ratio_reg;
    assign overflow       = o_ovf_reg;

    `VEMA_ASSERT(a_cnt_bound, (cnt_reg <= BOUND), "pair count past bound")
    `VEMA_ASSERT(a_ovf_at_bound, (ovf_reg |-> at_bound), "overflow below bound")
    `VEMA_ASSERT(a_div_idle, (div_start |-> !div_stat.busy), "divider restarted while busy")
    `VEMA_ASSERT(a_emit, ((state_reg == vema_pkg::S_OUT && !out_valid_reg) |=> out_valid_reg),
        "result not posted")

endmodule

[hw/rtl/vector_error_metric_accumulator_core.sv]
// Top level of the vector error metric accumulator.
// Each accepted pair passes through the back end in order: it is taken from the queue, then
// goes through one shared 25x25 squarer, then two 25-step square roots on one shared
// root unit, then an accumulate step. A pair that arrives once the run already holds
// 2^COUNT_BITS pairs is dropped. A pair marking the end of a run adds two
// passes of a shared one-bit-per-cycle divider, and a third when the mean magnitude is
// above the floor register, and a final state to post the result. A two-entry queue
// takes pairs while the back end works, and the next run starts while a posted result
// waits to be taken.
module vector_error_metric_accumulator_core #(
    parameter int COUNT_BITS = vema_pkg::COUNT_BITS_DEF,
    parameter int FRAC_BITS  = vema_pkg::FRAC_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [15:0]   cfg_data,
    input  logic          s_tvalid,
    output logic          s_tready,
    // measured_x, measured_y, measured_z, reference_x, reference_y, reference_z
    input  logic [143:0]  s_tdata,
    input  logic          s_tlast,
    output logic          m_tvalid,
    input  logic          m_tready,
    // pair_count, mean_error, peak_error, mean_magnitude, ratio_error, zero fill
    output logic [127:0]  m_tdata,
    // overflow
    output logic          m_tuser
);
    logic [vema_pkg::FLOOR_W-1:0] floor_reg;
    logic                         q_full, q_empty, q_pop;
    logic [vema_pkg::ITEM_W-1:0]  q_head;
    logic [16:0] pair_count;
    logic [24:0] mean_error, peak_error;
    logic [23:0] mean_magnitude;
    logic [31:0] ratio_error;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_reg <= '0;
        end
        else if (cfg_valid)
        begin
            floor_reg <= cfg_data;
        end
    end

    vema_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_tvalid),
        .push_data ({s_tlast, s_tdata}),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    vema_back #(
        .COUNT_BITS (COUNT_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .q_head         (q_head),
        .q_pop          (q_pop),
        .floor_val      (floor_reg),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .pair_count     (pair_count),
        .mean_error     (mean_error),
        .peak_error     (peak_error),
        .mean_magnitude (mean_magnitude),
        .ratio_error    (ratio_error),
        .overflow       (m_tuser)
    );

    assign m_tdata = {5'b0, ratio_error, mean_magnitude, peak_error, mean_error, pair_count};

endmodule
